>>> sv/pfra_pkg.sv
// ----------------------------------------------------------------------------
// pfra_pkg
// Shared types and constants for the page frame reference-count allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package pfra_pkg;

   // Frame table geometry
   localparam int NUM_FRAMES    = 16384;
   localparam int IDX_W         = $clog2(NUM_FRAMES);
   localparam int PAGE_SHIFT    = 12;
   localparam int ADDR_W        = 32;
   localparam int OFF_W         = ADDR_W - PAGE_SHIFT;
   localparam int COUNT_W       = 8;
   localparam int RSV_W         = 15;
   localparam int CMP_W         = ((IDX_W > RSV_W) ? IDX_W : RSV_W) + 1;

   // Count values
   localparam logic [COUNT_W-1:0] COUNT_ZERO     = '0;
   localparam logic [COUNT_W-1:0] COUNT_ONE      = COUNT_W'(1);
   localparam logic [COUNT_W-1:0] COUNT_MAX      = '1;
   localparam logic [COUNT_W-1:0] RESERVED_MARK  = COUNT_W'(100);

   // Register reset values
   localparam logic [ADDR_W-1:0] BASE_RESET      = ADDR_W'(1048576);
   localparam logic [RSV_W-1:0]  RESERVED_RESET  = RSV_W'(896);

   // Stream packing
   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 48;

   typedef enum logic [2:0] {
      ACT_INIT  = 3'd0,
      ACT_ALLOC = 3'd1,
      ACT_FREE  = 3'd2,
      ACT_SHARE = 3'd3,
      ACT_QUERY = 3'd4
   } action_type;

   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_NONE_FREE    = 3'd1,
      ST_DOUBLE_FREE  = 3'd2,
      ST_OUT_OF_RANGE = 3'd3,
      ST_OVERFLOW     = 3'd4
   } status_type;

   typedef enum logic [0:0] {
      CSR_BASE     = 1'b0,
      CSR_RESERVED = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      FSM_CLEAR,
      FSM_IDLE,
      FSM_LOOKUP,
      FSM_MODIFY,
      FSM_SCAN,
      FSM_DONE
   } fsm_type;

endpackage

`default_nettype wire

>>> sv/page_frame_refcount_allocator_unit.sv
// Free, share and query read the count and write it back; out-of-range requests
// skip the update. Allocate scans downward from the top frame for a zero count.
// Init reruns the clearing pass over the whole table.
// One transaction at a time: req_tready is low until the result enters the
// output register.
// Reset runs a clearing pass over every frame with req_tready low; csr writes apply.
// ----------------------------------------------------------------------------
// page_frame_refcount_allocator_unit
// Byte-wide reference count per 4 KiB page frame, with a downward free scan.
// ----------------------------------------------------------------------------
`default_nettype none

module page_frame_refcount_allocator_unit
   import pfra_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // csr write port
   input  wire logic                  csr_we,
   input  wire logic [0:0]            csr_index,
   input  wire logic [ADDR_W-1:0]     csr_wdata,
   // request stream
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,  // [2:0] action, [34:3] page_address
   // response stream
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   output      logic [RSP_DATA_W-1:0] rsp_tdata   // [31:0] frame_address,
                                                  // [39:32] ref_count, [42:40] status
);

   // Registers
   fsm_type                state_ff, state_in;
   logic [ADDR_W-1:0]      base_ff;
   logic [RSV_W-1:0]       reserved_ff;
   action_type             act_ff;
   logic [ADDR_W-1:0]      addr_ff;
   logic [IDX_W-1:0]       clr_idx_ff, clr_idx_in;
   logic [RSV_W-1:0]       sweep_lim_ff, sweep_lim_in;
   logic                   clr_req_ff, clr_req_in;
   logic [IDX_W-1:0]       scan_idx_ff, scan_idx_in;
   logic                   scan_more_ff, scan_more_in;
   logic                   rd_pend_ff, rd_pend_in;
   logic [IDX_W-1:0]       rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]       rmw_idx_ff, rmw_idx_in;
   logic [COUNT_W-1:0]     rd_data_ff;
   logic [ADDR_W-1:0]      res_faddr_ff, res_faddr_in;
   logic [COUNT_W-1:0]     res_count_ff, res_count_in;
   status_type             res_status_ff, res_status_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]      rsp_faddr_ff;
   logic [COUNT_W-1:0]     rsp_count_ff;
   status_type             rsp_status_ff;

   // Count memory
   logic [COUNT_W-1:0]     mem [NUM_FRAMES];
   logic                   mem_we;
   logic [IDX_W-1:0]       mem_wa;
   logic [COUNT_W-1:0]     mem_wd;
   logic [IDX_W-1:0]       mem_ra;

   // Decode helpers
   logic                   req_accept;
   logic                   out_free;
   logic [ADDR_W-1:0]      diff;
   logic [OFF_W-1:0]       off;
   logic                   in_range;
   logic                   scan_hit;
   logic                   scan_miss;
   logic                   clr_last;

   assign req_accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == FSM_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Locate the frame that holds the request address
   assign diff     = addr_ff - base_ff;
   assign off      = diff[ADDR_W-1:PAGE_SHIFT];
   assign in_range = (addr_ff >= base_ff) &&
                     ((OFF_W+1)'(off) < (OFF_W+1)'(NUM_FRAMES));

   assign scan_hit  = rd_pend_ff && (rd_data_ff == COUNT_ZERO);
   assign scan_miss = !scan_more_ff && !rd_pend_ff;
   assign clr_last  = (clr_idx_ff == IDX_W'(NUM_FRAMES - 1));

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_CLEAR: begin
            if (clr_last) begin
               state_in = clr_req_ff ? FSM_DONE : FSM_IDLE;
            end
         end
         FSM_IDLE: begin
            if (req_accept) begin
               priority case (action_type'(req_tdata[2:0]))
                  ACT_INIT:  state_in = FSM_CLEAR;
                  ACT_ALLOC: state_in = FSM_SCAN;
                  ACT_FREE, ACT_SHARE, ACT_QUERY: state_in = FSM_LOOKUP;
                  default:   state_in = FSM_DONE;
               endcase
            end
         end
         FSM_LOOKUP: state_in = in_range ? FSM_MODIFY : FSM_DONE;
         FSM_MODIFY: state_in = FSM_DONE;
         FSM_SCAN: begin
            if (scan_hit || scan_miss) begin
               state_in = FSM_DONE;
            end
         end
         FSM_DONE: begin
            if (out_free) begin
               state_in = FSM_IDLE;
            end
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   // Datapath and memory control
   always_comb begin
      clr_idx_in    = clr_idx_ff;
      sweep_lim_in  = sweep_lim_ff;
      clr_req_in    = clr_req_ff;
      scan_idx_in   = scan_idx_ff;
      scan_more_in  = scan_more_ff;
      rd_pend_in    = 1'b0;
      rd_idx_in     = rd_idx_ff;
      rmw_idx_in    = rmw_idx_ff;
      res_faddr_in  = res_faddr_ff;
      res_count_in  = res_count_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      mem_we        = 1'b0;
      mem_wa        = clr_idx_ff;
      mem_wd        = COUNT_ZERO;
      mem_ra        = scan_idx_ff;

      unique case (state_ff)
         // sweep the table: reserved frames get the mark, the rest zero
         FSM_CLEAR: begin
            mem_we     = 1'b1;
            mem_wa     = clr_idx_ff;
            mem_wd     = (CMP_W'(clr_idx_ff) < CMP_W'(sweep_lim_ff)) ?
                         RESERVED_MARK : COUNT_ZERO;
            clr_idx_in = clr_idx_ff + IDX_W'(1);
            if (clr_last) begin
               clr_idx_in = '0;
               clr_req_in = 1'b0;
            end
         end
         // take a transaction and reset the result
         FSM_IDLE: begin
            res_faddr_in  = '0;
            res_count_in  = COUNT_ZERO;
            res_status_in = ST_OK;
            scan_idx_in   = IDX_W'(NUM_FRAMES - 1);
            scan_more_in  = 1'b1;
            if (req_accept) begin
               sweep_lim_in = reserved_ff;
               clr_req_in   = 1'b1;
               clr_idx_in   = '0;
            end
         end
         // check range and issue the count read
         FSM_LOOKUP: begin
            rmw_idx_in = off[IDX_W-1:0];
            mem_ra     = off[IDX_W-1:0];
            if (!in_range) begin
               res_status_in = ST_OUT_OF_RANGE;
            end
         end
         // update the count and write it back
         FSM_MODIFY: begin
            res_count_in = rd_data_ff;
            unique case (act_ff)
               ACT_FREE: begin
                  if (rd_data_ff == COUNT_ZERO) begin
                     res_status_in = ST_DOUBLE_FREE;
                  end else begin
                     res_count_in = rd_data_ff - COUNT_ONE;
                  end
               end
               ACT_SHARE: begin
                  if (rd_data_ff == COUNT_MAX) begin
                     res_status_in = ST_OVERFLOW;
                  end else begin
                     res_count_in = rd_data_ff + COUNT_ONE;
                  end
               end
               default: begin
               end
            endcase
            mem_we = 1'b1;
            mem_wa = rmw_idx_ff;
            mem_wd = res_count_in;
         end
         // walk down the table one read per cycle, claim the first free frame
         FSM_SCAN: begin
            if (scan_hit) begin
               mem_we        = 1'b1;
               mem_wa        = rd_idx_ff;
               mem_wd        = COUNT_ONE;
               res_faddr_in  = base_ff + (ADDR_W'(rd_idx_ff) << PAGE_SHIFT);
               res_count_in  = COUNT_ONE;
               res_status_in = ST_OK;
            end else if (scan_miss) begin
               res_status_in = ST_NONE_FREE;
            end else if (scan_more_ff) begin
               mem_ra      = scan_idx_ff;
               rd_pend_in  = 1'b1;
               rd_idx_in   = scan_idx_ff;
               scan_idx_in = scan_idx_ff - IDX_W'(1);
               if (scan_idx_ff == '0) begin
                  scan_more_in = 1'b0;
               end
            end
         end
         // hand the result to the output register once it is free
         FSM_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_CLEAR;
         clr_idx_ff   <= '0;
         sweep_lim_ff <= RESERVED_RESET;
         clr_req_ff   <= 1'b0;
         scan_more_ff <= 1'b0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         sweep_lim_ff <= sweep_lim_in;
         clr_req_ff   <= clr_req_in;
         scan_more_ff <= scan_more_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff     <= BASE_RESET;
         reserved_ff <= RESERVED_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_BASE:     base_ff     <= csr_wdata;
            CSR_RESERVED: reserved_ff <= csr_wdata[RSV_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         act_ff  <= action_type'(req_tdata[2:0]);
         addr_ff <= req_tdata[ADDR_W+2:3];
      end
      scan_idx_ff   <= scan_idx_in;
      rd_idx_ff     <= rd_idx_in;
      rmw_idx_ff    <= rmw_idx_in;
      res_faddr_ff  <= res_faddr_in;
      res_count_ff  <= res_count_in;
      res_status_ff <= res_status_in;
      if (state_ff == FSM_DONE && out_free) begin
         rsp_faddr_ff  <= res_faddr_ff;
         rsp_count_ff  <= res_count_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   // Count memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[mem_ra];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_status_ff, rsp_count_ff, rsp_faddr_ff};

   // Assertions
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_tready)
      else $error("block ready right after taking a transaction");

   a_scan_claims_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_SCAN && mem_we) |-> (rd_data_ff == COUNT_ZERO))
      else $error("allocate scan claimed a frame in use");

   a_none_free_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == ST_NONE_FREE) |->
         (rsp_faddr_ff == '0 && rsp_count_ff == COUNT_ZERO))
      else $error("failed allocate carries an address or count");

   a_reset_clears: assert property (@(posedge clock)
      ($past(reset) && !reset) |-> (state_ff == FSM_CLEAR && !rsp_valid_ff))
      else $error("reset did not start the clearing pass");

endmodule

`default_nettype wire

>>> dv/page_frame_refcount_allocator_unit_test.sv
// ----------------------------------------------------------------------------
// page_frame_refcount_allocator_unit_test
// Self-checking bench for the page frame reference-count allocator. A local
// copy of the frame count table predicts every response. Directed tests come
// first: reset contents, register extremes, count saturation and a long
// response stall. Random traffic follows: allocate/free/share/query with
// rare init and undefined actions, and random idle cycles on both streams.
// ----------------------------------------------------------------------------

module page_frame_refcount_allocator_unit_test
   import pfra_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int          CLOCK_PERIOD = 20;
   localparam int unsigned CYCLE_LIMIT  = 20_000_000;
   localparam int unsigned PRINT_LIMIT  = 40;
   localparam int unsigned LIVE_DEPTH   = 64;

   // Expected content of one response transaction
   typedef struct packed {
      logic [ADDR_W-1:0]  frame_address;
      logic [COUNT_W-1:0] ref_count;
      status_type         status;
   } frame_result_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [0:0]            csr_index;
   logic [ADDR_W-1:0]     csr_wdata;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // [2:0] action, [34:3] page_address
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // [31:0] frame_address, [39:32] ref_count,
                                       // [42:40] status

   // Shadow copy of the block state and registers
   logic [COUNT_W-1:0] frame_count_shadow [NUM_FRAMES];
   logic [ADDR_W-1:0]  cfg_base;
   logic [RSV_W-1:0]   cfg_reserved;

   frame_result_type pending_frame_results [$];
   int unsigned      live_frames [$];
   int unsigned      error_count   = 0;
   int unsigned      cycle_count   = 0;
   int unsigned      rsp_hold_left = 0;
   int unsigned      req_calm_left = 0;

   page_frame_refcount_allocator_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TIMEOUT after %0d cycles, %0d results outstanding", cycle_count,
                  pending_frame_results.size());
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      if (error_count < PRINT_LIMIT)
         $display("MISMATCH at %0t: %s", $time, msg);
      error_count++;
   endtask

   // Idle length: mostly none or short, a few long, with calm stretches
   function automatic int unsigned idle_length(inout int unsigned calm);
      int unsigned r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm = $urandom_range(10, 40);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(15, 50);
   endfunction

   // Clear the table and mark the lowest frames reserved
   function automatic void reserve_frames_shadow();
      int unsigned n;
      n = (cfg_reserved > NUM_FRAMES) ? NUM_FRAMES : cfg_reserved;
      for (int i = 0; i < NUM_FRAMES; i++)
         frame_count_shadow[i] = (i < n) ? RESERVED_MARK : COUNT_ZERO;
   endfunction

   // Apply one action to the shadow table and return its response
   function automatic frame_result_type apply_frame_action(input logic [2:0] act,
                                                           input logic [ADDR_W-1:0] addr);
      frame_result_type   r;
      logic [ADDR_W-1:0]  offset;
      logic [ADDR_W-1:0]  frame_off;
      logic [COUNT_W-1:0] c;
      int                 i;
      int unsigned        idx;
      bit                 found;
      r = '0;
      r.status = ST_OK;
      case (act)
         ACT_INIT: begin
            reserve_frames_shadow();
         end
         ACT_ALLOC: begin
            // Scan downward for the first unused frame
            r.status = ST_NONE_FREE;
            found = 1'b0;
            i = NUM_FRAMES - 1;
            while (!found && i >= 0) begin
               if (frame_count_shadow[i] == COUNT_ZERO) begin
                  found = 1'b1;
                  frame_count_shadow[i] = COUNT_ONE;
                  frame_off = i;
                  r.frame_address = cfg_base + (frame_off << PAGE_SHIFT);
                  r.ref_count = COUNT_ONE;
                  r.status = ST_OK;
               end
               i--;
            end
         end
         ACT_FREE, ACT_SHARE, ACT_QUERY: begin
            offset = addr - cfg_base;
            if (addr < cfg_base || (offset >> PAGE_SHIFT) >= NUM_FRAMES) begin
               r.status = ST_OUT_OF_RANGE;
            end else begin
               idx = offset >> PAGE_SHIFT;
               c = frame_count_shadow[idx];
               if (act == ACT_FREE) begin
                  if (c == COUNT_ZERO) r.status = ST_DOUBLE_FREE;
                  else c--;
               end else if (act == ACT_SHARE) begin
                  if (c == COUNT_MAX) r.status = ST_OVERFLOW;
                  else c++;
               end
               frame_count_shadow[idx] = c;
               r.ref_count = c;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // Offer one request transaction and record its expected response
   task automatic send_request(input logic [2:0] act, input logic [ADDR_W-1:0] addr,
                               output frame_result_type want);
      int unsigned gap;
      gap = idle_length(req_calm_left);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'({addr, act});
      do @(posedge clock); while (!req_tready);
      want = apply_frame_action(act, addr);
      pending_frame_results.push_back(want);
   endtask

   // Drop valid and wait until every response is back
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (pending_frame_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Write both registers while the block is idle
   task automatic write_config(input logic [ADDR_W-1:0] base,
                               input logic [RSV_W-1:0] reserved);
      wait_for_results();
      csr_we    <= 1'b1;
      csr_index <= CSR_BASE;
      csr_wdata <= base;
      @(posedge clock);
      csr_index <= CSR_RESERVED;
      csr_wdata <= {{(ADDR_W - RSV_W){1'b0}}, reserved};
      @(posedge clock);
      csr_we    <= 1'b0;
      cfg_base     = base;
      cfg_reserved = reserved;
   endtask

   // Response sink: check each transaction, stall at random
   initial begin : rsp_sink
      int unsigned      stall_left;
      int unsigned      calm_left;
      frame_result_type want;
      frame_result_type got;
      stall_left = 0;
      calm_left  = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got.frame_address = rsp_tdata[31:0];
            got.ref_count     = rsp_tdata[39:32];
            got.status        = status_type'(rsp_tdata[42:40]);
            if (pending_frame_results.size() == 0) begin
               report_mismatch($sformatf("response %h with no request outstanding",
                                         rsp_tdata));
            end else begin
               want = pending_frame_results.pop_front();
               if (got.frame_address !== want.frame_address)
                  report_mismatch($sformatf("frame_address %h, expected %h",
                                            got.frame_address, want.frame_address));
               if (got.ref_count !== want.ref_count)
                  report_mismatch($sformatf("ref_count %0d, expected %0d",
                                            got.ref_count, want.ref_count));
               if (got.status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            got.status, want.status));
            end
         end
         // Long hold-off first, then random stalls
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            stall_left = idle_length(calm_left);
            rsp_tready <= (stall_left == 0);
            if (stall_left > 0) stall_left--;
         end
      end
   end

   // Counts left by reset, range edges, allocate, free, share and undefined actions
   task automatic test_reset_contents();
      frame_result_type want;
      send_request(ACT_QUERY, BASE_RESET, want);
      send_request(ACT_QUERY, BASE_RESET + 32'h0037_FFFF, want);
      send_request(ACT_QUERY, BASE_RESET + 32'h0038_0000, want);
      send_request(ACT_QUERY, BASE_RESET - 32'd1, want);
      send_request(ACT_QUERY, 32'h0000_0000, want);
      send_request(ACT_QUERY, BASE_RESET + 32'h0400_0000, want);
      send_request(ACT_QUERY, 32'hFFFF_FFFF, want);
      send_request(ACT_ALLOC, $urandom(), want);
      send_request(ACT_ALLOC, $urandom(), want);
      send_request(ACT_FREE, BASE_RESET + 32'h03FF_F000, want);
      send_request(ACT_FREE, BASE_RESET + 32'h03FF_FABC, want);
      send_request(ACT_SHARE, BASE_RESET + 32'h03FF_E001, want);
      send_request(ACT_FREE, BASE_RESET + 32'h03FF_EFFF, want);
      send_request(ACT_SHARE, BASE_RESET + 32'h0038_0800, want);
      send_request(ACT_FREE, BASE_RESET, want);
      send_request(ACT_FREE, BASE_RESET - 32'h0000_1000, want);
      send_request(ACT_SHARE, 32'h0000_0FFF, want);
      send_request(ACT_ALLOC, 32'h0000_0000, want);
      send_request(3'd5, $urandom(), want);
      send_request(3'd6, 32'hFFFF_FFFF, want);
      send_request(3'd7, BASE_RESET, want);
   endtask

   // Extreme base and reserve settings, address wrap, empty pool
   task automatic test_config_extremes();
      frame_result_type want;
      write_config(32'hFFFF_F000, 15'd0);
      send_request(ACT_INIT, $urandom(), want);
      send_request(ACT_ALLOC, $urandom(), want);
      send_request(ACT_QUERY, 32'hFFFF_F000, want);
      send_request(ACT_SHARE, 32'hFFFF_FFFF, want);
      send_request(ACT_FREE, 32'hFFFF_F123, want);
      send_request(ACT_FREE, 32'hFFFF_F000, want);
      send_request(ACT_QUERY, 32'h03FF_E000, want);
      // Reserve beyond the table fills every frame
      write_config(32'h0000_0000, 15'h7FFF);
      send_request(ACT_INIT, $urandom(), want);
      send_request(ACT_ALLOC, $urandom(), want);
      send_request(ACT_QUERY, 32'h03FF_F000, want);
      send_request(ACT_QUERY, 32'h0400_0000, want);
      send_request(ACT_FREE, 32'h0000_0000, want);
   endtask

   // Share one frame until its count saturates
   task automatic test_count_overflow();
      frame_result_type want;
      write_config(32'hFFFF_FFFF, 15'd16384);
      send_request(ACT_INIT, $urandom(), want);
      send_request(ACT_QUERY, 32'hFFFF_FFFF, want);
      repeat (int'(COUNT_MAX) - int'(RESERVED_MARK)) send_request(ACT_SHARE, 32'hFFFF_FFFF, want);
      send_request(ACT_SHARE, 32'hFFFF_FFFF, want);
      send_request(ACT_QUERY, 32'hFFFF_FFFE, want);
      send_request(ACT_FREE, 32'hFFFF_FFFF, want);
   endtask

   // Hold the response side off while requests keep coming
   task automatic test_backpressure();
      frame_result_type want;
      write_config(BASE_RESET, RESERVED_RESET);
      send_request(ACT_INIT, $urandom(), want);
      wait_for_results();
      rsp_hold_left = 200;
      for (int i = 0; i < 24; i++) begin
         case (i % 3)
            0:       send_request(ACT_ALLOC, $urandom(), want);
            1:       send_request(ACT_SHARE, BASE_RESET + 32'h03FF_F000, want);
            default: send_request(ACT_QUERY, BASE_RESET + 32'h03FF_F000, want);
         endcase
      end
   endtask

   // Address near allocated frames, reserve edges, or anywhere
   function automatic logic [ADDR_W-1:0] pick_page_address();
      int unsigned       mode;
      int unsigned       idx;
      int unsigned       n;
      logic [ADDR_W-1:0] frame_off;
      mode = $urandom_range(0, 99);
      n = (cfg_reserved > NUM_FRAMES) ? NUM_FRAMES : cfg_reserved;
      if (mode >= 85) return $urandom();
      if (mode < 60 && live_frames.size() > 0) begin
         idx = live_frames[$urandom_range(0, live_frames.size() - 1)];
      end else if (mode < 75) begin
         idx = $urandom_range(0, NUM_FRAMES - 1);
      end else begin
         case ($urandom_range(0, 3))
            0:       idx = 0;
            1:       idx = (n > 0) ? n - 1 : 0;
            2:       idx = (n < NUM_FRAMES) ? n : NUM_FRAMES - 1;
            default: idx = NUM_FRAMES - 1;
         endcase
      end
      frame_off = idx;
      return cfg_base + (frame_off << PAGE_SHIFT) + $urandom_range(0, 4095);
   endfunction

   // Random allocate, free, share and query, mostly on the frames handed out, with rare init and undefined actions
   task automatic run_random_phase(input logic [ADDR_W-1:0] base,
                                   input logic [RSV_W-1:0] reserved,
                                   input int unsigned count);
      frame_result_type  want;
      logic [2:0]        act;
      logic [ADDR_W-1:0] offset;
      int unsigned       r;
      write_config(base, reserved);
      send_request(ACT_INIT, $urandom(), want);
      live_frames.delete();
      repeat (count) begin
         r = $urandom_range(0, 999);
         if (r < 5)        act = ACT_INIT;
         else if (r < 260) act = ACT_ALLOC;
         else if (r < 510) act = ACT_FREE;
         else if (r < 690) act = ACT_SHARE;
         else if (r < 950) act = ACT_QUERY;
         else              act = 3'($urandom_range(5, 7));
         send_request(act, pick_page_address(), want);
         if (act == ACT_INIT) begin
            live_frames.delete();
         end else if (act == ACT_ALLOC && want.status == ST_OK) begin
            offset = want.frame_address - cfg_base;
            live_frames.push_back(offset >> PAGE_SHIFT);
            if (live_frames.size() > LIVE_DEPTH) void'(live_frames.pop_front());
         end
      end
   endtask

   task automatic test_random_traffic();
      run_random_phase(BASE_RESET, RESERVED_RESET, 230);
      run_random_phase($urandom(), RSV_W'($urandom_range(0, NUM_FRAMES)), 230);
      run_random_phase(32'h0000_0000, 15'd16000, 230);
   endtask

   initial begin
      reset      <= 1'b1;
      csr_we     <= 1'b0;
      csr_index  <= CSR_BASE;
      csr_wdata  <= '0;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      cfg_base     = BASE_RESET;
      cfg_reserved = RESERVED_RESET;
      reserve_frames_shadow();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      // Wait out the clearing pass
      do @(posedge clock); while (!req_tready);

      test_reset_contents();
      test_config_extremes();
      test_count_overflow();
      test_backpressure();
      test_random_traffic();

      wait_for_results();
      repeat (20) @(posedge clock);
      if (pending_frame_results.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived",
                                   pending_frame_results.size()));
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

>>> page_frame_refcount_allocator_unit.f
sv/pfra_pkg.sv
sv/page_frame_refcount_allocator_unit.sv
dv/page_frame_refcount_allocator_unit_test.sv
